// ===== src/aeac_pkg.sv =====
// ----------------------------------------------------------------------------
// aeac_pkg
// shared constants and types of the array element address calculator
// ----------------------------------------------------------------------------
package aeac_pkg;

  // default sizing, handed to the top level parameters
  localparam int unsigned NUM_ARRAYS_DEF = 16;
  localparam int unsigned MAX_DIMS_DEF   = 8;

  // payload field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ID_FW    = 4;
  localparam int unsigned DIM_FW   = 3;
  localparam int unsigned BASE_W   = 31;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned DATA_W   = 32;

  // action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_HEADER = 2'd0,
    ACT_BOUNDS = 2'd1,
    ACT_INDEX  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // descriptor memory word
  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
  } desc_t;

  // dimension memory word
  typedef struct packed {
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] extent;
  } dim_t;

endpackage

// ===== src/aeac_ifs.sv =====
// ----------------------------------------------------------------------------
// aeac channel interfaces
// valid/ready channels for descriptor and index transactions and address results
// ----------------------------------------------------------------------------
interface aeac_in_if;
  logic                              valid;
  logic                              ready;
  logic [aeac_pkg::ACTION_W-1:0]     action;
  logic [aeac_pkg::ID_FW-1:0]        array_id;
  logic [aeac_pkg::DIM_FW-1:0]       dim;
  logic [aeac_pkg::BASE_W-1:0]       base_addr;
  logic [aeac_pkg::SIZE_W-1:0]       elem_size;
  logic [aeac_pkg::COUNT_W-1:0]      dim_count;
  logic signed [aeac_pkg::DATA_W-1:0] lower_bound;
  logic signed [aeac_pkg::DATA_W-1:0] upper_bound;
  logic signed [aeac_pkg::DATA_W-1:0] index_value;

  modport source (
    output valid, action, array_id, dim, base_addr, elem_size, dim_count,
           lower_bound, upper_bound, index_value,
    input  ready
  );
  modport sink (
    input  valid, action, array_id, dim, base_addr, elem_size, dim_count,
           lower_bound, upper_bound, index_value,
    output ready
  );
endinterface

interface aeac_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [aeac_pkg::DATA_W-1:0] address;
  logic [aeac_pkg::ID_FW-1:0]         ref_array;

  modport source (
    output valid, address, ref_array,
    input  ready
  );
  modport sink (
    input  valid, address, ref_array,
    output ready
  );
endinterface

// ===== src/array_element_address_calc_top.sv =====
// ----------------------------------------------------------------------------
// array_element_address_calc_top
// row-major element address calculator over a table of array descriptors
// ----------------------------------------------------------------------------
// a header transaction stores base address, element size and dimension count
// of one array; a bounds transaction stores the lower bound and the extent
// (upper - lower + 1) of one dimension; index transactions, one per dimension
// in order, run a horner accumulator acc = acc * extent + (index - lower),
// restarted by dimension 0, and the index on the final dimension yields
// base + elem_size * acc, wrapped to 32 bits. header, bounds and ignored
// transactions do not start the sequencer. an index transaction first reads
// the descriptor and dimension memories synchronously, then does the 32x32
// multiply-add of the accumulator. the final index adds an address step for
// the element size multiply, which overlaps the acceptance of the next
// transaction while the result register is free. array ids wrap modulo
// NUM_ARRAYS; dimensions at or above MAX_DIMS are ignored; descriptors must be
// written before they are referenced. no clearing pass after reset; the input
// is held off while reset is asserted.
// ----------------------------------------------------------------------------
module array_element_address_calc_top #(
  parameter int unsigned NUM_ARRAYS = aeac_pkg::NUM_ARRAYS_DEF,
  parameter int unsigned MAX_DIMS   = aeac_pkg::MAX_DIMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  aeac_in_if.sink    in_ch,
  aeac_out_if.source out_ch
);

  localparam int unsigned ID_W   = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
  localparam int unsigned SLOTS  = NUM_ARRAYS * MAX_DIMS;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IDS    = 1 << aeac_pkg::ID_FW;
  localparam int unsigned DW     = aeac_pkg::DATA_W;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_ADR  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // memories
  aeac_pkg::desc_t desc_mem [NUM_ARRAYS];
  aeac_pkg::dim_t  dim_mem  [SLOTS];
  aeac_pkg::desc_t desc_rd_r;
  aeac_pkg::dim_t  dim_rd_r;

  // held fields of the index in flight
  logic [aeac_pkg::DIM_FW-1:0] item_dim_r;
  logic [DW-1:0]               item_idx_r;
  logic [aeac_pkg::ID_FW-1:0]  item_id_r;

  logic [DW-1:0] acc_r, acc_nxt;

  // result register
  logic                       out_valid_r, out_valid_nxt;
  logic [DW-1:0]              out_addr_r;
  logic [aeac_pkg::ID_FW-1:0] out_id_r;

  logic in_ready;
  logic accept;
  logic out_free;
  logic dim_ok;
  logic is_header, is_bounds, is_index;
  logic final_dim;
  logic load_out;

  logic [ID_W-1:0]    id_tab [IDS];
  logic [ID_W-1:0]    id_w;
  logic [12:0]        slot_wide;
  logic [SLOT_W-1:0]  slot_w;
  logic [aeac_pkg::COUNT_W-1:0] cnt_clamped;
  logic [DW-1:0]      extent_w;
  logic [DW-1:0]      off_w;
  logic [DW-1:0]      mac_prod;
  logic [DW-1:0]      size_prod;
  logic [DW-1:0]      addr_w;

  // array id modulo NUM_ARRAYS as a constant lookup
  for (genvar r = 0; r < IDS; r++) begin : g_id_tab
    localparam int unsigned IdVal = r % NUM_ARRAYS;
    assign id_tab[r] = ID_W'(IdVal);
  end

  assign id_w      = id_tab[in_ch.array_id];
  assign slot_wide = 13'(id_w) * 13'(MAX_DIMS) + 13'(in_ch.dim);
  assign slot_w    = slot_wide[SLOT_W-1:0];

  assign dim_ok    = ({2'b00, in_ch.dim} < 5'(MAX_DIMS));
  assign is_header = (in_ch.action == aeac_pkg::ACT_HEADER);
  assign is_bounds = (in_ch.action == aeac_pkg::ACT_BOUNDS) && dim_ok;
  assign is_index  = (in_ch.action == aeac_pkg::ACT_INDEX) && dim_ok;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = rst_n &&
                    ((state_r == ST_IDLE) || ((state_r == ST_ADR) && out_free));
  assign accept   = in_ch.valid && in_ready;

  // header count clamped into 1..MAX_DIMS
  always_comb begin
    cnt_clamped = in_ch.dim_count;
    if (in_ch.dim_count == '0) begin
      cnt_clamped = aeac_pkg::COUNT_W'(1);
    end else if ({1'b0, in_ch.dim_count} > 5'(MAX_DIMS)) begin
      cnt_clamped = aeac_pkg::COUNT_W'(MAX_DIMS);
    end
  end

  assign extent_w = in_ch.upper_bound - in_ch.lower_bound + DW'(1);

  // descriptor memory: written by headers, read by indices
  always_ff @(posedge clk) begin
    if (accept && is_header) begin
      desc_mem[id_w] <= '{base: in_ch.base_addr, size: in_ch.elem_size,
                          count: cnt_clamped};
    end
    if (accept && is_index) begin
      desc_rd_r <= desc_mem[id_w];
    end
  end

  // dimension memory: written by bounds, read by indices
  always_ff @(posedge clk) begin
    if (accept && is_bounds) begin
      dim_mem[slot_w] <= '{lower: in_ch.lower_bound, extent: extent_w};
    end
    if (accept && is_index) begin
      dim_rd_r <= dim_mem[slot_w];
    end
  end

  // fields of the index transaction, held for the following cycles
  always_ff @(posedge clk) begin
    if (accept && is_index) begin
      item_dim_r <= in_ch.dim;
      item_idx_r <= in_ch.index_value;
      item_id_r  <= in_ch.array_id;
    end
  end

  // horner step, low 32 bits of the product only
  assign off_w    = item_idx_r - dim_rd_r.lower;
  assign mac_prod = acc_r * dim_rd_r.extent;

  always_comb begin
    acc_nxt = acc_r;
    if (state_r == ST_MAC) begin
      if (item_dim_r == '0) begin
        acc_nxt = off_w;
      end else begin
        acc_nxt = mac_prod + off_w;
      end
    end
  end

  // last dimension when dim + 1 equals the stored count
  assign final_dim = (({2'b00, item_dim_r} + 5'd1) == {1'b0, desc_rd_r.count});

  // element address from the committed accumulator
  assign size_prod = DW'(desc_rd_r.size) * acc_r;
  assign addr_w    = DW'({1'b0, desc_rd_r.base}) + size_prod;

  assign load_out = (state_r == ST_ADR) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_index) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        state_nxt = final_dim ? ST_ADR : ST_IDLE;
      end
      ST_ADR: begin
        if (out_free) begin
          state_nxt = (accept && is_index) ? ST_MAC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_addr_r <= addr_w;
      out_id_r   <= item_id_r;
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.address   = out_addr_r;
  assign out_ch.ref_array = out_id_r;

  // an accepted in-range index always moves to the horner step
  a_index_to_mac: assert property (
    @(posedge clk) disable iff (!rst_n)
    (accept && is_index) |=> (state_r == ST_MAC)
  ) else $error("index transaction did not enter the horner step");

  // a new result only appears after the address step
  a_result_from_adr: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == ST_ADR)
  ) else $error("result raised outside the address step");

  // the address step never lingers while the result register is empty
  a_adr_no_stall: assert property (
    @(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ADR) && !out_valid_r) |=> (state_r != ST_ADR)
  ) else $error("address step stalled with a free result register");

endmodule
